### design/dctr_pkg.sv
// Shared types and constants for the down-counter timer register block.
package dctr_pkg;

    localparam int COUNT_WIDTH = 32;

    localparam int CMD_W  = 2;
    localparam int OFF_W  = 3;
    localparam int DATA_W = 32;
    localparam int CTL_W  = 8;
    localparam int PRE_W  = 8;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2
    } cmd_t;

    typedef enum logic [OFF_W-1:0] {
        REG_LOAD   = 3'd0,
        REG_VALUE  = 3'd1,
        REG_CTRL   = 3'd2,
        REG_INTCLR = 3'd3,
        REG_RIS    = 3'd4,
        REG_MIS    = 3'd5,
        REG_BGLOAD = 3'd6,
        REG_UNUSED = 3'd7
    } reg_off_t;

    // Control register bit positions
    localparam int CTL_ONESHOT_BIT  = 0;
    localparam int CTL_WIDE_BIT     = 1;
    localparam int CTL_PRE_LO_BIT   = 2;
    localparam int CTL_RSVD_BIT     = 4;
    localparam int CTL_IE_BIT       = 5;
    localparam int CTL_PERIODIC_BIT = 6;
    localparam int CTL_ENABLE_BIT   = 7;

    localparam logic [CTL_W-1:0] CTL_WRITABLE = 8'hEF;
    localparam logic [CTL_W-1:0] CTL_RESET    = 8'h20;

    localparam logic [1:0] PRE_DIV16  = 2'd1;
    localparam logic [1:0] PRE_DIV256 = 2'd2;

    localparam logic [PRE_W:0] DIV_1   = 9'd1;
    localparam logic [PRE_W:0] DIV_16  = 9'd16;
    localparam logic [PRE_W:0] DIV_256 = 9'd256;

    function automatic logic [DATA_W-1:0] zext_count(input logic [COUNT_WIDTH-1:0] c);
        logic [DATA_W-1:0] r;
        r = '0;
        r[COUNT_WIDTH-1:0] = c;
        return r;
    endfunction

    // Active count mask: full width when the wide bit is set, else low 16 bits
    function automatic logic [COUNT_WIDTH-1:0] active_mask(input logic wide);
        logic [COUNT_WIDTH-1:0] m;
        m = '1;
        if (!wide)
        begin
            m = '0;
            m[15:0] = 16'hFFFF;
        end
        return m;
    endfunction

endpackage

### design/down_counter_timer_registers_core.sv
// Top level of the down-counter timer channel with its register file.
//
// Usage:
//   Slave channel s_*: one transfer per command. s_tuser carries the command
//   (tick, register read, register write); s_tdata carries the register word
//   offset and the write data. Master channel m_*: exactly one result
//   transfer per command, in order, carrying the read data (zero unless the
//   command is a read) and the interrupt line after the command took effect.
//   Path: an accepted command lands in the input register; its result is then
//   loaded into the result register, which drives m_*.
//   Throughput: one command per cycle while m_* is not stalled; the counter
//   state is updated combinationally between the two registers.
//   Stall: while m_tready is low the result is held; one more command may
//   wait in the input register, after which s_tready drops.
//   Reset (rst_n low): both registers empty, reload zero, counter all ones,
//   control 0x20 (interrupt enable set, timer disabled), raw interrupt and
//   prescaler cleared.
module down_counter_timer_registers_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [2:0] reg_offset, [34:3] write_data, [39:35] zero
    input  logic [dctr_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] command
    input  logic [dctr_pkg::CMD_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [31:0] read_data, [32] irq_out, [39:33] zero
    output logic [dctr_pkg::M_TDATA_W-1:0] m_tdata
);
    import dctr_pkg::*;

    logic                   in_valid_reg;
    logic [CMD_W-1:0]       in_cmd_reg;
    logic [OFF_W-1:0]       in_off_reg;
    logic [DATA_W-1:0]      in_data_reg;

    logic                   out_valid_reg;
    logic [DATA_W-1:0]      out_rd_reg;
    logic                   out_irq_reg;

    logic [DATA_W-1:0]      reload_reg, reload_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [CTL_W-1:0]       ctrl_reg, ctrl_next;
    logic                   raw_reg, raw_next;
    logic [PRE_W-1:0]       pre_reg, pre_next;

    logic [DATA_W-1:0]      rd_next;
    logic                   advance;

    logic [COUNT_WIDTH-1:0] mask;
    logic [COUNT_WIDTH-1:0] cur;
    logic [COUNT_WIDTH-1:0] dec;
    logic [PRE_W:0]         pre_inc;
    logic [PRE_W:0]         divider;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - DATA_W - 1){1'b0}}, out_irq_reg, out_rd_reg};

    assign mask    = active_mask(ctrl_reg[CTL_WIDE_BIT]);
    assign cur     = count_reg & mask;
    assign pre_inc = {1'b0, pre_reg} + {{PRE_W{1'b0}}, 1'b1};

    always_comb
    begin
        case (ctrl_reg[CTL_PRE_LO_BIT +: 2])
            PRE_DIV16:  divider = DIV_16;
            PRE_DIV256: divider = DIV_256;
            default:    divider = DIV_1;
        endcase
    end

    // Value after one prescaled count
    always_comb
    begin
        if (cur == '0)
        begin
            if (ctrl_reg[CTL_PERIODIC_BIT])
                dec = reload_reg[COUNT_WIDTH-1:0] & mask;
            else
                dec = mask;
        end
        else
        begin
            dec = cur - {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
        end
    end

    always_comb
    begin
        reload_next = reload_reg;
        count_next  = count_reg;
        ctrl_next   = ctrl_reg;
        raw_next    = raw_reg;
        pre_next    = pre_reg;
        rd_next     = '0;
        case (cmd_t'(in_cmd_reg))
            CMD_TICK:
            begin
                if (ctrl_reg[CTL_ENABLE_BIT])
                begin
                    if (pre_inc >= divider)
                    begin
                        pre_next = '0;
                        // Halt at zero in one-shot mode
                        if (!(cur == '0 && ctrl_reg[CTL_ONESHOT_BIT]))
                        begin
                            count_next = dec;
                            if (dec == '0)
                                raw_next = 1'b1;
                        end
                    end
                    else
                    begin
                        pre_next = pre_inc[PRE_W-1:0];
                    end
                end
            end
            CMD_READ:
            begin
                case (reg_off_t'(in_off_reg))
                    REG_LOAD:   rd_next = reload_reg;
                    REG_VALUE:  rd_next = zext_count(cur);
                    REG_CTRL:   rd_next = {{(DATA_W-CTL_W){1'b0}}, ctrl_reg};
                    REG_RIS:    rd_next = {{(DATA_W-1){1'b0}}, raw_reg};
                    REG_MIS:    rd_next = {{(DATA_W-1){1'b0}},
                                           raw_reg & ctrl_reg[CTL_IE_BIT]};
                    REG_BGLOAD: rd_next = reload_reg;
                    default:    rd_next = '0;
                endcase
            end
            CMD_WRITE:
            begin
                case (reg_off_t'(in_off_reg))
                    REG_LOAD:
                    begin
                        reload_next = in_data_reg;
                        count_next  = in_data_reg[COUNT_WIDTH-1:0] & mask;
                    end
                    REG_CTRL:   ctrl_next   = in_data_reg[CTL_W-1:0] & CTL_WRITABLE;
                    REG_INTCLR: raw_next    = 1'b0;
                    REG_BGLOAD: reload_next = in_data_reg;
                    default:    ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            reload_reg    <= '0;
            count_reg     <= '1;
            ctrl_reg      <= CTL_RESET;
            raw_reg       <= 1'b0;
            pre_reg       <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (advance)
            begin
                reload_reg <= reload_next;
                count_reg  <= count_next;
                ctrl_reg   <= ctrl_next;
                raw_reg    <= raw_next;
                pre_reg    <= pre_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_cmd_reg  <= s_tuser;
            in_off_reg  <= s_tdata[OFF_W-1:0];
            in_data_reg <= s_tdata[OFF_W +: DATA_W];
        end
        if (advance)
        begin
            out_rd_reg  <= rd_next;
            out_irq_reg <= raw_next & ctrl_next[CTL_IE_BIT];
        end
    end

`ifndef SYNTH
    a_raw_rise_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(raw_reg) |-> ((count_reg & active_mask(ctrl_reg[CTL_WIDE_BIT])) == '0))
        else $error("raw interrupt rose with nonzero count");

    a_disabled_tick_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_cmd_reg == CMD_TICK && !ctrl_reg[CTL_ENABLE_BIT])
        |=> ($stable(count_reg) && $stable(pre_reg) && $stable(raw_reg)))
        else $error("disabled timer changed on tick");

    a_reserved_bit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !ctrl_reg[CTL_RSVD_BIT])
        else $error("reserved control bit set");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty result register");
`endif

endmodule
